// File: rtl/core/fqp_pkg.sv
`timescale 1ns / 1ps

package fqp_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_WIDTH = 8;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        FN_ENQ   = 2'd0,
        FN_DEQ   = 2'd1,
        FN_PURGE = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NULL     = 3'd4
    } t_status;

endpackage

// File: rtl/core/fifo_queue_with_purge_core.sv
`timescale 1ns / 1ps

// Bounded queue of process ids, kept compacted from slot 0.
// Input channel: i_in_valid, o_in_stall, i_func, i_proc_id. A word is taken at a
// rising edge with i_in_valid high and o_in_stall low. Output channel: o_out_valid,
// i_out_stall, o_status, o_removed_id, o_count, o_is_empty; exactly one result word
// is produced for every input word, in order.
// Enqueue, rejected operations and the unused selector register their result at
// the edge that takes the input word.
// Dequeue and purge run on a slot memory with one read and one write port and one
// id comparator; a dequeue takes slot 0 as its match. Each slot visited in the
// search takes a read and a compare step, and each slot moved to close the gap
// takes a read and a write step, followed by a finish step. A dequeue moves every
// later slot down; a purge that finds nothing visits every slot.
// The block takes one word at a time and holds o_in_stall high while it works. The
// next word can be taken at the edge after the result is registered, so words that
// finish when taken can follow every cycle while the receiver does not stall.
// When the receiver stalls, the result word holds, and a new input word is taken
// only once the output register is free or is being taken in the same cycle.
// A synchronous reset empties the queue and drops any pending result; slot
// contents are not cleared since only slots below the fill count are read.
module fifo_queue_with_purge_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [7:0]           i_proc_id,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic [7:0]           o_removed_id,
    output logic [4:0]           o_count,
    output logic                 o_is_empty
);
    import fqp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_CMP   = 6'b000100,
        S_SH_RD = 6'b001000,
        S_SH_WR = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [IDX_W-1:0]     r_idx, n_idx;
    t_func                r_func, n_func;
    logic [ID_WIDTH-1:0]  r_id, n_id;
    t_status              r_status, n_status;
    logic [ID_WIDTH-1:0]  r_removed, n_removed;

    logic                 r_out_valid, n_out_valid;
    t_status              r_o_status, n_o_status;
    logic [ID_WIDTH-1:0]  r_o_removed, n_o_removed;
    logic [CNT_W-1:0]     r_o_count, n_o_count;

    logic [ID_WIDTH-1:0]  r_slots [DEPTH];
    logic [ID_WIDTH-1:0]  r_rdata;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ID_WIDTH-1:0]  mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    logic                 in_take;
    logic                 out_take;
    logic [ID_WIDTH-1:0]  in_id;
    logic [CNT_W-1:0]     idx_p1;
    logic [CNT_W-1:0]     idx_p2;
    logic                 id_match;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign in_id      = ID_WIDTH'(i_proc_id);
    assign idx_p1     = CNT_W'(r_idx) + CNT_W'(1);
    assign idx_p2     = CNT_W'(r_idx) + CNT_W'(2);
    assign id_match   = (r_func == FN_DEQ) || (r_rdata == r_id);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_func      = r_func;
        n_id        = r_id;
        n_status    = r_status;
        n_removed   = r_removed;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        n_o_status  = r_o_status;
        n_o_removed = r_o_removed;
        n_o_count   = r_o_count;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_rdata;
        mem_raddr   = r_idx;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_func      = t_func'(i_func);
                    n_id        = in_id;
                    n_idx       = '0;
                    n_removed   = '0;
                    n_o_removed = '0;
                    n_o_count   = r_fill;
                    n_o_status  = ST_OK;
                    n_out_valid = 1'b1;
                    case (t_func'(i_func))
                        FN_ENQ: begin
                            if (in_id == '0) begin
                                n_o_status = ST_NULL;
                            end else if (r_fill >= CNT_W'(DEPTH)) begin
                                n_o_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_fill[IDX_W-1:0];
                                mem_wdata = in_id;
                                n_fill    = r_fill + CNT_W'(1);
                                n_o_count = r_fill + CNT_W'(1);
                            end
                        end
                        FN_DEQ: begin
                            if (r_fill == '0) begin
                                n_o_status = ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !out_take;
                                n_state     = S_RD;
                            end
                        end
                        FN_PURGE: begin
                            if (in_id == '0) begin
                                n_o_status = ST_NULL;
                            end else if (r_fill == '0) begin
                                n_o_status = ST_NOTFOUND;
                            end else begin
                                n_out_valid = r_out_valid && !out_take;
                                n_state     = S_RD;
                            end
                        end
                        default: begin
                            n_o_status = ST_OK;
                        end
                    endcase
                end
            end
            S_RD: begin
                mem_raddr = r_idx;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (id_match) begin
                    n_removed = r_rdata;
                    n_status  = ST_OK;
                    n_state   = (idx_p1 < r_fill) ? S_SH_RD : S_FIN;
                end else if (idx_p1 < r_fill) begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD;
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_FIN;
                end
            end
            S_SH_RD: begin
                mem_raddr = r_idx + IDX_W'(1);
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rdata;
                n_idx     = r_idx + IDX_W'(1);
                n_state   = (idx_p2 < r_fill) ? S_SH_RD : S_FIN;
            end
            S_FIN: begin
                n_out_valid = 1'b1;
                n_o_status  = r_status;
                n_o_removed = r_removed;
                if (r_status == ST_OK) begin
                    n_fill    = r_fill - CNT_W'(1);
                    n_o_count = r_fill - CNT_W'(1);
                end else begin
                    n_o_count = r_fill;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slots[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_slots[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_func      <= n_func;
        r_id        <= n_id;
        r_status    <= n_status;
        r_removed   <= n_removed;
        r_o_status  <= n_o_status;
        r_o_removed <= n_o_removed;
        r_o_count   <= n_o_count;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_removed_id = 8'(r_o_removed);
    assign o_count      = 5'(r_o_count);
    assign o_is_empty   = (r_o_count == '0);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count exceeds queue depth");

    a_fin_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_out_valid)
        else $error("result finished while output register still holds a word");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_RD || r_state == S_SH_WR) |-> (idx_p1 < r_fill))
        else $error("gap shift reads beyond the fill count");

    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CMP) |-> (r_fill != '0))
        else $error("search started on an empty queue");

    a_fin_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_IDLE && r_out_valid))
        else $error("finish step did not deliver a result");

endmodule
